/* design/i8sdp_pkg.sv */
// Package for the int8 scaled dot product unit.
// Holds field widths, register indexes, reset values and the queue entry type.
// Depends on nothing.
package i8sdp_pkg;

	localparam int LANE_W    = 8;
	localparam int MAX_LANES = 8;
	localparam int WORD_W    = 64;
	localparam int PROD_W    = 16;
	localparam int SUM_W     = 20;
	localparam int ACC_W     = 32;
	localparam int SCALE_W   = 32;
	localparam int ROW_W     = 18;
	localparam int LOGIT_W   = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ROW    = 2'd1;

	localparam logic [SCALE_W-1:0] VECTOR_SCALE_RESET = 32'h0100_0000;

	localparam logic [63:0] POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAG = 64'h0000_8000_0000_0000;

	typedef struct packed {
		logic [ACC_W-1:0]   total;
		logic [SCALE_W-1:0] row_scale;
		logic [ROW_W-1:0]   row;
	} q_entry_t;

endpackage

/* design/i8sdp_ifs.sv */
// Handshake channels of the int8 scaled dot product unit: items, logits, register writes.
// Depends on i8sdp_pkg.
interface i8sdp_in_if;
	logic                             valid;
	logic                             ready;
	logic [i8sdp_pkg::WORD_W-1:0]     row_lanes;
	logic [i8sdp_pkg::WORD_W-1:0]     act_lanes;
	logic [i8sdp_pkg::SCALE_W-1:0]    row_scale;
	logic                             last_of_row;
	modport source (output valid, row_lanes, act_lanes, row_scale, last_of_row, input ready);
	modport sink (input valid, row_lanes, act_lanes, row_scale, last_of_row, output ready);
endinterface

interface i8sdp_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [i8sdp_pkg::LOGIT_W-1:0] logit_value;
	logic [i8sdp_pkg::ROW_W-1:0]         row_index;
	modport source (output valid, logit_value, row_index, input ready);
	modport sink (input valid, logit_value, row_index, output ready);
endinterface

interface i8sdp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [i8sdp_pkg::CFG_IDX_W-1:0]   index;
	logic [i8sdp_pkg::CFG_DAT_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/i8sdp_front.sv */
// Front end: accepts lane words, multiplies lanes, accumulates the row total
// and pushes finished rows to the queue. Depends on i8sdp_pkg and i8sdp_ifs.
module i8sdp_front #(
	parameter int LANES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	i8sdp_in_if.sink                       item,
	input  logic [i8sdp_pkg::ROW_W-1:0]    start_row,
	input  logic                           full,
	output logic                           push,
	output i8sdp_pkg::q_entry_t            push_entry
);

	localparam int LANES_USED = (LANES < i8sdp_pkg::MAX_LANES) ? LANES : i8sdp_pkg::MAX_LANES;
	localparam int EXT_W      = i8sdp_pkg::ACC_W - i8sdp_pkg::SUM_W;

	logic                                   valid_s1;
	logic                                   last_s1;
	logic [i8sdp_pkg::SCALE_W-1:0]          rs_s1;
	logic signed [i8sdp_pkg::PROD_W-1:0]    prod_s1 [LANES_USED];
	logic [i8sdp_pkg::ACC_W-1:0]            acc_q;
	logic [i8sdp_pkg::ROW_W-1:0]            rows_done_q;
	logic signed [i8sdp_pkg::SUM_W-1:0]     lane_sum;
	logic [i8sdp_pkg::ACC_W-1:0]            acc_next;
	logic                                   adv;
	logic                                   take;

	assign adv        = valid_s1 && (!last_s1 || !full);
	assign item.ready = !valid_s1 || adv;
	assign take       = item.valid && item.ready;

	always_comb begin
		lane_sum = '0;
		for (int i = 0; i < LANES_USED; i++) begin
			lane_sum = lane_sum + i8sdp_pkg::SUM_W'(prod_s1[i]);
		end
		acc_next = acc_q + {{EXT_W{lane_sum[i8sdp_pkg::SUM_W-1]}}, lane_sum};
	end

	assign push                 = adv && last_s1;
	assign push_entry.total     = acc_next;
	assign push_entry.row_scale = rs_s1;
	assign push_entry.row       = start_row + rows_done_q;

	always_ff @(posedge clk) begin
		if (take) begin
			last_s1 <= item.last_of_row;
			rs_s1   <= item.row_scale;
			for (int i = 0; i < LANES_USED; i++) begin
				prod_s1[i] <= $signed(item.row_lanes[i*i8sdp_pkg::LANE_W +: i8sdp_pkg::LANE_W])
					* $signed(item.act_lanes[i*i8sdp_pkg::LANE_W +: i8sdp_pkg::LANE_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			acc_q       <= '0;
			rows_done_q <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				if (last_s1) begin
					acc_q       <= '0;
					rows_done_q <= rows_done_q + 1'b1;
				end else begin
					acc_q <= acc_next;
				end
			end
		end
	end

endmodule

/* design/i8sdp_queue.sv */
// Short queue of finished row totals between the front and back ends.
// Depends on i8sdp_pkg.
module i8sdp_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  i8sdp_pkg::q_entry_t  push_entry,
	output logic                 full,
	input  logic                 pop,
	output i8sdp_pkg::q_entry_t  pop_entry,
	output logic                 empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	i8sdp_pkg::q_entry_t  slot_q [DEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [CW-1:0]        cnt_q;

	assign full      = cnt_q == CW'(DEPTH);
	assign empty     = cnt_q == '0;
	assign pop_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("queue pushed while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue popped while empty");

endmodule

/* design/i8sdp_back.sv */
// Back end: scales a row total by row and vector scales with one shared
// 32x32 multiplier, saturates to Q.16 and holds the logit. Depends on i8sdp_pkg, i8sdp_ifs.
module i8sdp_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [i8sdp_pkg::SCALE_W-1:0]   vector_scale,
	input  i8sdp_pkg::q_entry_t             pop_entry,
	input  logic                            empty,
	output logic                            pop,
	i8sdp_out_if.source                     result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAG  = 3'd1;
	localparam logic [2:0] ST_LO   = 3'd2;
	localparam logic [2:0] ST_HI   = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_SAT  = 3'd5;

	logic [2:0]                         state_q;
	logic                               neg_q;
	logic [31:0]                        mag_q;
	logic [i8sdp_pkg::SCALE_W-1:0]      rs_q;
	logic [i8sdp_pkg::ROW_W-1:0]        row_q;
	logic [63:0]                        a_q;
	logic [63:0]                        lo_q;
	logic [63:0]                        hi_q;
	logic [63:0]                        q_q;
	logic                               out_valid_q;
	logic signed [i8sdp_pkg::LOGIT_W-1:0] logit_q;
	logic [i8sdp_pkg::ROW_W-1:0]        row_out_q;
	logic [31:0]                        mul_a;
	logic [31:0]                        mul_b;
	logic [63:0]                        mul_p;
	logic [63:0]                        neg_mag;
	logic [i8sdp_pkg::LOGIT_W-1:0]      sat_val;
	logic                               out_free;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		unique case (state_q)
			ST_MAG: begin
				mul_a = mag_q;
				mul_b = rs_q;
			end
			ST_LO: begin
				mul_a = a_q[31:0];
				mul_b = vector_scale;
			end
			ST_HI: begin
				mul_a = a_q[63:32];
				mul_b = vector_scale;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		neg_mag = (q_q > i8sdp_pkg::NEG_MAG) ? i8sdp_pkg::NEG_MAG : q_q;
		if (neg_q) begin
			sat_val = ~neg_mag[i8sdp_pkg::LOGIT_W-1:0] + 1'b1;
		end else if (q_q > i8sdp_pkg::POS_MAX) begin
			sat_val = i8sdp_pkg::POS_MAX[i8sdp_pkg::LOGIT_W-1:0];
		end else begin
			sat_val = q_q[i8sdp_pkg::LOGIT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				neg_q <= pop_entry.total[31];
				mag_q <= pop_entry.total[31] ? (~pop_entry.total + 1'b1) : pop_entry.total;
				rs_q  <= pop_entry.row_scale;
				row_q <= pop_entry.row;
			end
			ST_MAG: a_q <= mul_p;
			ST_LO:  lo_q <= mul_p;
			ST_HI:  hi_q <= mul_p;
			ST_SUM: q_q <= hi_q + {32'd0, lo_q[63:32]} + {63'd0, neg_q && (lo_q[31:0] != '0)};
			default: begin
				if (out_free) begin
					logit_q   <= $signed(sat_val);
					row_out_q <= row_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (!empty) state_q <= ST_MAG;
				ST_MAG:  state_q <= ST_LO;
				ST_LO:   state_q <= ST_HI;
				ST_HI:   state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_SAT;
				default: if (out_free) state_q <= ST_IDLE;
			endcase
			if (state_q == ST_SAT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.logit_value = logit_q;
	assign result.row_index   = row_out_q;

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop) else $error("pop outside idle");

	a_sat_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SAT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("logit not loaded");

endmodule

/* design/int8_scaled_dot_product_unit.sv */
// Top level of the int8 scaled dot product unit: register file, front end,
// queue and back end. Depends on i8sdp_pkg, i8sdp_ifs and the i8sdp modules.
//
// Use: each word on "item" carries eight int8 row lanes, eight int8 activation
// lanes, the row scale (Q8.24) and a last-of-row flag. Lane products add into
// a 32-bit row total; on the last word the total is scaled by row_scale and
// vector_scale, shifted down by 32, saturated to 48 bits and sent on "result"
// with its row index (start_row plus rows completed, mod 2^18).
// "cfg" writes vector_scale (index 0) or start_row (index 1); it is always
// ready and other indexes are ignored. Write only while the unit is idle.
// Throughput: one item per cycle on the front end unless a finished row waits on
// a full queue; the back end takes one row at a time through its shared 32x32
// multiplier sequence, so rows that arrive faster fill the QUEUE_DEPTH-entry queue and then throttle "item".
// Each row total passes the product register, the queue and the back-end states in order.
// Reset clears the accumulator, row count, queue and output valid flag and sets
// vector_scale to 1.0. A stalled "result" holds its logit; the back end then
// waits and the queue, then "item", back up behind it.
module int8_scaled_dot_product_unit #(
	parameter int LANES       = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	i8sdp_in_if.sink      item,
	i8sdp_out_if.source   result,
	i8sdp_cfg_if.sink     cfg
);

	logic [i8sdp_pkg::SCALE_W-1:0] vector_scale_q;
	logic [i8sdp_pkg::ROW_W-1:0]   start_row_q;
	logic                          push;
	logic                          pop;
	logic                          full;
	logic                          empty;
	i8sdp_pkg::q_entry_t           push_entry;
	i8sdp_pkg::q_entry_t           pop_entry;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_scale_q <= i8sdp_pkg::VECTOR_SCALE_RESET;
			start_row_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				i8sdp_pkg::CFG_VECTOR_SCALE: vector_scale_q <= cfg.data;
				i8sdp_pkg::CFG_START_ROW:    start_row_q <= cfg.data[i8sdp_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	i8sdp_front #(
		.LANES (LANES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.start_row  (start_row_q),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	i8sdp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (empty)
	);

	i8sdp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.vector_scale (vector_scale_q),
		.pop_entry    (pop_entry),
		.empty        (empty),
		.pop          (pop),
		.result       (result)
	);

endmodule

/* tb/i8sdp_logit_check.sv */
// Checker for the int8 scaled dot product unit: watches the item, result and
// register-write channels, predicts each logit and compares it on arrival.
// Depends on i8sdp_pkg and the channel interfaces in i8sdp_ifs.
module i8sdp_logit_check (
	input  logic  clk,
	input  logic  arst_n,
	i8sdp_in_if   item,
	i8sdp_out_if  result,
	i8sdp_cfg_if  cfg,
	output int    mismatches,
	output int    outstanding
);

	localparam int WIDE_W = i8sdp_pkg::ACC_W + 2 * i8sdp_pkg::SCALE_W + 2;

	typedef struct {
		logic signed [i8sdp_pkg::LOGIT_W-1:0] logit;
		logic [i8sdp_pkg::ROW_W-1:0]          row;
	} logit_t;

	logic [i8sdp_pkg::SCALE_W-1:0]      vec_scale;
	logic [i8sdp_pkg::ROW_W-1:0]        first_row;
	logic signed [i8sdp_pkg::ACC_W-1:0] row_total;
	logic [i8sdp_pkg::ROW_W-1:0]        rows_seen;
	logit_t                             due_logits[$];

	function automatic logic signed [i8sdp_pkg::ACC_W-1:0] lane_dot(
			input logic [i8sdp_pkg::WORD_W-1:0] r, input logic [i8sdp_pkg::WORD_W-1:0] a);
		logic signed [i8sdp_pkg::ACC_W-1:0] s;
		int i;
		s = '0;
		for (i = 0; i < i8sdp_pkg::MAX_LANES; i++)
			s = s + $signed(r[i*i8sdp_pkg::LANE_W +: i8sdp_pkg::LANE_W])
				* $signed(a[i*i8sdp_pkg::LANE_W +: i8sdp_pkg::LANE_W]);
		return s;
	endfunction

	// floor(total * rs * vs / 2^32), clamped to the signed logit range
	function automatic logic signed [i8sdp_pkg::LOGIT_W-1:0] scaled_logit(
			input logic signed [i8sdp_pkg::ACC_W-1:0] total,
			input logic [i8sdp_pkg::SCALE_W-1:0] rs,
			input logic [i8sdp_pkg::SCALE_W-1:0] vs);
		logic signed [WIDE_W-1:0] wide;
		logic signed [WIDE_W-1:0] upper;
		logic signed [WIDE_W-1:0] lower;
		upper = $signed({{(WIDE_W-64){1'b0}}, i8sdp_pkg::POS_MAX});
		lower = -$signed({{(WIDE_W-64){1'b0}}, i8sdp_pkg::NEG_MAG});
		wide = total;
		wide = wide * $signed({{(WIDE_W-i8sdp_pkg::SCALE_W){1'b0}}, rs});
		wide = wide * $signed({{(WIDE_W-i8sdp_pkg::SCALE_W){1'b0}}, vs});
		wide = wide >>> 32;
		if (wide > upper)
			wide = upper;
		else if (wide < lower)
			wide = lower;
		return wide[i8sdp_pkg::LOGIT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logit_t due;
		if (!arst_n) begin
			vec_scale = i8sdp_pkg::VECTOR_SCALE_RESET;
			first_row = '0;
			row_total = '0;
			rows_seen = '0;
			due_logits.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (due_logits.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected logit %0d row %0d", result.logit_value,
							result.row_index);
				end else begin
					due = due_logits.pop_front();
					if (result.logit_value !== due.logit || result.row_index !== due.row) begin
						mismatches++;
						if (mismatches <= 10)
							$display("logit mismatch: expected %0d row %0d, got %0d row %0d",
								due.logit, due.row, result.logit_value, result.row_index);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					i8sdp_pkg::CFG_VECTOR_SCALE: vec_scale = cfg.data[i8sdp_pkg::SCALE_W-1:0];
					i8sdp_pkg::CFG_START_ROW:    first_row = cfg.data[i8sdp_pkg::ROW_W-1:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				row_total = row_total + lane_dot(item.row_lanes, item.act_lanes);
				if (item.last_of_row) begin
					due.logit = scaled_logit(row_total, item.row_scale, vec_scale);
					due.row = first_row + rows_seen;
					due_logits.push_back(due);
					row_total = '0;
					rows_seen = rows_seen + 1'b1;
				end
			end
		end
		outstanding = due_logits.size();
	end

endmodule

/* tb/int8_scaled_dot_product_unit_test.sv */
// Testbench top for the int8 scaled dot product unit: clock, reset, item and
// register-write stimulus, result back-pressure and the verdict.
// Depends on i8sdp_pkg, i8sdp_ifs, the unit itself and i8sdp_logit_check.
module int8_scaled_dot_product_unit_test;

	localparam logic [i8sdp_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [i8sdp_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	localparam logic [i8sdp_pkg::SCALE_W-1:0]   SCALE_ONE    = 32'h0100_0000;
	localparam logic [i8sdp_pkg::SCALE_W-1:0]   SCALE_MAX    = 32'hFFFF_FFFF;
	localparam logic [i8sdp_pkg::WORD_W-1:0]    LANES_POS    = {8{8'h7F}};
	localparam logic [i8sdp_pkg::WORD_W-1:0]    LANES_NEG    = {8{8'h80}};
	localparam int RANDOM_WORDS  = 1600;
	localparam int PHASE_WORDS   = 400;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 12;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   random_words;
	bit   hold_request;

	i8sdp_in_if  item_if ();
	i8sdp_out_if result_if ();
	i8sdp_cfg_if cfg_if ();

	int8_scaled_dot_product_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	i8sdp_logit_check logit_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_if),
		.result      (result_if),
		.cfg         (cfg_if),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [i8sdp_pkg::WORD_W-1:0] pick_lanes();
		logic [i8sdp_pkg::WORD_W-1:0] w;
		int i;
		w = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0) begin
			for (i = 0; i < i8sdp_pkg::MAX_LANES; i++) begin
				case ($urandom_range(0, 3))
					0: w[i*i8sdp_pkg::LANE_W +: i8sdp_pkg::LANE_W] = 8'h80;
					1: w[i*i8sdp_pkg::LANE_W +: i8sdp_pkg::LANE_W] = 8'h7F;
					2: w[i*i8sdp_pkg::LANE_W +: i8sdp_pkg::LANE_W] = 8'hFF;
					default: ;
				endcase
			end
		end
		return w;
	endfunction

	function automatic logic [i8sdp_pkg::SCALE_W-1:0] pick_scale();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SCALE_MAX;
			2: return SCALE_ONE;
			3: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	function automatic int row_len();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 14)
			return $urandom_range(1, 5);
		if (sel < 19)
			return $urandom_range(6, 16);
		return $urandom_range(17, 64);
	endfunction

	function automatic int gap_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic push_word(input logic [i8sdp_pkg::WORD_W-1:0] r,
			input logic [i8sdp_pkg::WORD_W-1:0] a, input logic [i8sdp_pkg::SCALE_W-1:0] s,
			input logic last);
		item_if.valid       <= 1'b1;
		item_if.row_lanes   <= r;
		item_if.act_lanes   <= a;
		item_if.row_scale   <= s;
		item_if.last_of_row <= last;
		do @(posedge clk); while (!item_if.ready);
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			item_if.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_row(input int len, input logic [i8sdp_pkg::SCALE_W-1:0] s,
			input bit steady);
		int k;
		for (k = 0; k < len; k++) begin
			push_word(pick_lanes(), pick_lanes(), (k == len - 1) ? s : $urandom, k == len - 1);
			random_words++;
			if (!steady)
				idle_gap(gap_len());
		end
	endtask

	// hold the item side until every logit is back and the pipeline is empty
	task automatic settle();
		item_if.valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [i8sdp_pkg::CFG_IDX_W-1:0] idx,
			input logic [i8sdp_pkg::CFG_DAT_W-1:0] value, input bit more);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		if (!more)
			cfg_if.valid <= 1'b0;
	endtask

	initial begin
		int mode;
		int span;
		int k;
		result_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) begin
					@(posedge clk);
					result_if.ready <= 1'b0;
				end
			end
			mode = $urandom_range(0, 9);
			span = $urandom_range(1, 40);
			for (k = 0; k < span; k++) begin
				@(posedge clk);
				case (mode)
					0, 1, 2, 3: result_if.ready <= 1'b1;
					8:          result_if.ready <= $urandom_range(0, 1);
					9:          result_if.ready <= 1'b0;
					default:    result_if.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin
		int k;
		int phase_end;
		arst_n              <= 1'b0;
		item_if.valid       <= 1'b0;
		item_if.row_lanes   <= '0;
		item_if.act_lanes   <= '0;
		item_if.row_scale   <= '0;
		item_if.last_of_row <= 1'b0;
		cfg_if.valid        <= 1'b0;
		cfg_if.index        <= i8sdp_pkg::CFG_VECTOR_SCALE;
		cfg_if.data         <= '0;
		hold_request = 1'b0;
		random_words = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit scale, rows from zero
		push_word(LANES_POS, LANES_POS, SCALE_ONE, 1'b1);
		push_word(LANES_NEG, LANES_NEG, SCALE_MAX, 1'b1);
		push_word(LANES_NEG, LANES_POS, SCALE_MAX, 1'b1);
		push_word('0, '0, $urandom, 1'b1);
		push_word(64'hFF, 64'h01, 32'h1, 1'b1);
		push_word(LANES_POS, LANES_NEG, $urandom, 1'b0);
		push_word(pick_lanes(), pick_lanes(), $urandom, 1'b0);
		push_word(LANES_NEG, LANES_NEG, '0, 1'b1);
		settle();

		// full scales saturate both ways; row index wraps
		cfg_write(i8sdp_pkg::CFG_VECTOR_SCALE, SCALE_MAX, 1'b1);
		cfg_write(i8sdp_pkg::CFG_START_ROW, 32'hFFFF_FFFF, 1'b0);
		push_word(LANES_POS, LANES_POS, SCALE_MAX, 1'b1);
		push_word(LANES_NEG, LANES_POS, SCALE_MAX, 1'b1);
		push_word(64'hFF, 64'h01, 32'h1, 1'b1);
		settle();

		// spare indexes must be dropped; zero vector scale
		cfg_write(CFG_SPARE_LO, $urandom, 1'b1);
		cfg_write(CFG_SPARE_HI, $urandom, 1'b1);
		cfg_write(i8sdp_pkg::CFG_VECTOR_SCALE, '0, 1'b0);
		push_word(LANES_POS, LANES_POS, SCALE_MAX, 1'b1);
		settle();

		// long rows with large totals of both signs
		cfg_write(i8sdp_pkg::CFG_VECTOR_SCALE, SCALE_ONE, 1'b1);
		cfg_write(i8sdp_pkg::CFG_START_ROW, 32'h0003_FFF0, 1'b0);
		for (k = 0; k < 120; k++)
			push_word(LANES_NEG, LANES_NEG, SCALE_ONE, k == 119);
		for (k = 0; k < 100; k++)
			push_word(LANES_NEG, LANES_POS, SCALE_MAX, k == 99);
		settle();

		// stall the result side long enough for the item side to back up
		hold_request = 1'b1;
		for (k = 0; k < 60; k++)
			push_word(pick_lanes(), pick_lanes(), pick_scale(), 1'b1);
		settle();

		while (random_words < RANDOM_WORDS) begin
			cfg_write(i8sdp_pkg::CFG_VECTOR_SCALE, pick_scale(), 1'b1);
			cfg_write(i8sdp_pkg::CFG_START_ROW, $urandom, 1'b0);
			phase_end = random_words + PHASE_WORDS;
			while (random_words < phase_end)
				send_row(row_len(), pick_scale(), $urandom_range(0, 4) == 0);
			settle();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* int8_scaled_dot_product_unit.f */
design/i8sdp_pkg.sv
design/i8sdp_ifs.sv
design/i8sdp_front.sv
design/i8sdp_queue.sv
design/i8sdp_back.sv
design/int8_scaled_dot_product_unit.sv
tb/i8sdp_logit_check.sv
tb/int8_scaled_dot_product_unit_test.sv
